// ===== rtl/core/sexl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sexl_pkg
// Shared types and constants of the S-expression lexer.
// ----------------------------------------------------------------------------
package sexl_pkg;

    localparam logic [2:0] K_OPEN  = 3'd0;
    localparam logic [2:0] K_CLOSE = 3'd1;
    localparam logic [2:0] K_NUM   = 3'd2;
    localparam logic [2:0] K_STR   = 3'd3;
    localparam logic [2:0] K_SYM   = 3'd4;
    localparam logic [2:0] K_BOOL  = 3'd5;
    localparam logic [2:0] K_ERR   = 3'd6;

    localparam logic [7:0] C_LPAREN = 8'h28;
    localparam logic [7:0] C_RPAREN = 8'h29;
    localparam logic [7:0] C_QUOTE  = 8'h22;
    localparam logic [7:0] C_BSLASH = 8'h5C;
    localparam logic [7:0] C_LC_N   = 8'h6E;
    localparam logic [7:0] C_LC_T   = 8'h74;
    localparam logic [7:0] C_MINUS  = 8'h2D;
    localparam logic [7:0] C_DOT    = 8'h2E;
    localparam logic [7:0] C_HASH   = 8'h23;
    localparam logic [7:0] C_LC_F   = 8'h66;
    localparam logic [7:0] C_SPACE  = 8'h20;
    localparam logic [7:0] C_TAB    = 8'h09;
    localparam logic [7:0] C_NL     = 8'h0A;

    localparam int RESQ_DEPTH = 4;
    localparam int RESQ_AW    = $clog2(RESQ_DEPTH);
    localparam int RESQ_CW    = $clog2(RESQ_DEPTH + 1);

    typedef struct packed {
        logic       cmd;
        logic [7:0] ch;
    } t_sexl_item;

    typedef struct packed {
        logic [2:0] token_kind;
        logic [7:0] text_char;
        logic       token_last;
        logic       empty_token;
    } t_sexl_res;

    typedef struct packed {
        logic is_digit;
        logic is_sym;
        logic is_sep;
    } t_sexl_cls;

    typedef struct packed {
        logic       cmd;
        logic [7:0] ch;
        t_sexl_cls  cls;
    } t_sexl_req;

    typedef struct packed {
        logic [1:0] cnt;
        t_sexl_res  r0;
        t_sexl_res  r1;
    } t_sexl_wr;

    function automatic t_sexl_cls classify(input logic [7:0] c);
        t_sexl_cls k;
        k.is_digit = (c >= 8'h30) && (c <= 8'h39);
        k.is_sym   = (c >= 8'h21) && (c <= 8'h7E) && (c != C_LPAREN)
                     && (c != C_RPAREN) && (c != C_QUOTE);
        k.is_sep   = (c == C_SPACE) || (c == C_TAB) || (c == C_NL);
        return k;
    endfunction

endpackage

// ===== rtl/core/sexl_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sexl_front
// Accepts source requests, classifies the byte and queues them for the lexer.
// ----------------------------------------------------------------------------
module sexl_front import sexl_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    input  t_sexl_item i_item,
    output logic       full,
    output logic       o_req_valid,
    output t_sexl_req  o_req,
    input  logic       i_req_take
);

    t_sexl_req  r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       wr_en;
    logic       rd_en;
    t_sexl_req  req_in;

    assign full        = (r_cnt == 2'd2);
    assign o_req_valid = (r_cnt != 2'd0);
    assign o_req       = r_q[r_rp];
    assign wr_en       = push && !full;
    assign rd_en       = i_req_take && o_req_valid;

    always_comb begin
        req_in.cmd = i_item.cmd;
        req_in.ch  = i_item.ch;
        req_in.cls = classify(i_item.ch);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (wr_en) begin
                r_wp <= ~r_wp;
            end
            if (rd_en) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, wr_en} - {1'b0, rd_en};
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_q[r_wp] <= req_in;
        end
    end

endmodule

// ===== rtl/core/sexl_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sexl_back
// Lexer state machine: consumes classified requests, emits up to two results.
// ----------------------------------------------------------------------------
module sexl_back import sexl_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_req_valid,
    input  t_sexl_req i_req,
    output logic      o_req_take,
    input  logic      i_room,
    output t_sexl_wr  o_wr
);

    localparam logic [3:0] M_IDLE  = 4'd0;
    localparam logic [3:0] M_MINUS = 4'd1;
    localparam logic [3:0] M_HASH  = 4'd2;
    localparam logic [3:0] M_INT   = 4'd3;
    localparam logic [3:0] M_FRAC  = 4'd4;
    localparam logic [3:0] M_SYM   = 4'd5;
    localparam logic [3:0] M_STR   = 4'd6;
    localparam logic [3:0] M_ESC   = 4'd7;
    localparam logic [3:0] M_HALT  = 4'd8;

    logic [3:0] r_mode;
    logic [7:0] r_hc;
    logic       r_hv;
    logic [3:0] n_mode;
    logic [7:0] n_hc;
    logic       n_hv;

    logic       take;
    logic [7:0] c;
    logic [7:0] esc_c;
    logic       do_idle;
    t_sexl_res  ra;
    t_sexl_res  rb;
    logic       a_v;
    logic       b_v;

    assign take       = i_req_valid && i_room;
    assign o_req_take = take;
    assign c          = i_req.ch;

    always_comb begin
        n_mode  = r_mode;
        n_hc    = r_hc;
        n_hv    = r_hv;
        do_idle = 1'b0;
        a_v     = 1'b0;
        b_v     = 1'b0;
        ra      = '{token_kind: K_SYM, text_char: r_hc, token_last: 1'b0, empty_token: 1'b0};
        rb      = '{token_kind: K_ERR, text_char: c, token_last: 1'b1, empty_token: 1'b0};
        esc_c   = c;
        if (c == C_LC_N) begin
            esc_c = C_NL;
        end else if (c == C_LC_T) begin
            esc_c = C_TAB;
        end

        if (i_req.cmd) begin
            unique case (r_mode)
                M_MINUS, M_HASH, M_SYM: begin
                    a_v           = r_hv;
                    ra.token_last = 1'b1;
                end
                M_INT, M_FRAC: begin
                    a_v           = r_hv;
                    ra.token_kind = K_NUM;
                    ra.token_last = 1'b1;
                end
                M_STR: begin
                    a_v           = 1'b1;
                    ra.token_kind = K_STR;
                    ra.token_last = 1'b1;
                    if (!r_hv) begin
                        ra.text_char   = 8'h00;
                        ra.empty_token = 1'b1;
                    end
                end
                M_ESC: begin
                    a_v           = r_hv;
                    ra.token_kind = K_STR;
                    b_v           = 1'b1;
                    rb.token_kind = K_STR;
                    rb.text_char  = C_BSLASH;
                end
                M_HALT: begin
                end
                default: begin
                end
            endcase
            if (r_mode != M_HALT) begin
                n_mode = M_IDLE;
                n_hc   = 8'h00;
                n_hv   = 1'b0;
            end
        end else begin
            unique case (r_mode)
                M_IDLE: begin
                    do_idle = 1'b1;
                end
                M_MINUS, M_HASH, M_SYM: begin
                    if (r_mode == M_MINUS && i_req.cls.is_digit) begin
                        n_mode        = M_INT;
                        a_v           = r_hv;
                        ra.token_kind = K_NUM;
                        n_hc          = c;
                        n_hv          = 1'b1;
                    end else if (r_mode == M_HASH && (c == C_LC_T || c == C_LC_F)) begin
                        b_v           = 1'b1;
                        rb.token_kind = K_BOOL;
                        n_mode        = M_IDLE;
                        n_hc          = 8'h00;
                        n_hv          = 1'b0;
                    end else if (i_req.cls.is_sym) begin
                        n_mode = M_SYM;
                        a_v    = r_hv;
                        n_hc   = c;
                        n_hv   = 1'b1;
                    end else begin
                        a_v           = r_hv;
                        ra.token_last = 1'b1;
                        n_mode        = M_IDLE;
                        n_hc          = 8'h00;
                        n_hv          = 1'b0;
                        do_idle       = 1'b1;
                    end
                end
                M_INT, M_FRAC: begin
                    ra.token_kind = K_NUM;
                    a_v           = r_hv;
                    if (i_req.cls.is_digit) begin
                        n_hc = c;
                        n_hv = 1'b1;
                    end else if (r_mode == M_INT && c == C_DOT) begin
                        n_mode = M_FRAC;
                        n_hc   = c;
                        n_hv   = 1'b1;
                    end else begin
                        ra.token_last = 1'b1;
                        n_mode        = M_IDLE;
                        n_hc          = 8'h00;
                        n_hv          = 1'b0;
                        do_idle       = 1'b1;
                    end
                end
                M_STR: begin
                    ra.token_kind = K_STR;
                    if (c == C_BSLASH) begin
                        n_mode = M_ESC;
                    end else if (c == C_QUOTE) begin
                        a_v           = 1'b1;
                        ra.token_last = 1'b1;
                        if (!r_hv) begin
                            ra.text_char   = 8'h00;
                            ra.empty_token = 1'b1;
                        end
                        n_mode = M_IDLE;
                        n_hc   = 8'h00;
                        n_hv   = 1'b0;
                    end else begin
                        a_v  = r_hv;
                        n_hc = c;
                        n_hv = 1'b1;
                    end
                end
                M_ESC: begin
                    ra.token_kind = K_STR;
                    a_v           = r_hv;
                    n_mode        = M_STR;
                    n_hc          = esc_c;
                    n_hv          = 1'b1;
                end
                M_HALT: begin
                end
                default: begin
                end
            endcase
        end

        if (do_idle) begin
            priority if (i_req.cls.is_sep) begin
            end else if (c == C_LPAREN) begin
                b_v           = 1'b1;
                rb.token_kind = K_OPEN;
            end else if (c == C_RPAREN) begin
                b_v           = 1'b1;
                rb.token_kind = K_CLOSE;
            end else if (c == C_MINUS) begin
                n_mode = M_MINUS;
                n_hc   = c;
                n_hv   = 1'b1;
            end else if (c == C_HASH) begin
                n_mode = M_HASH;
                n_hc   = c;
                n_hv   = 1'b1;
            end else if (i_req.cls.is_digit) begin
                n_mode = M_INT;
                n_hc   = c;
                n_hv   = 1'b1;
            end else if (c == C_QUOTE) begin
                n_mode = M_STR;
                n_hc   = 8'h00;
                n_hv   = 1'b0;
            end else if (i_req.cls.is_sym) begin
                n_mode = M_SYM;
                n_hc   = c;
                n_hv   = 1'b1;
            end else begin
                b_v    = 1'b1;
                n_mode = M_HALT;
                n_hc   = 8'h00;
                n_hv   = 1'b0;
            end
        end

        o_wr.cnt = take ? ({1'b0, a_v} + {1'b0, b_v}) : 2'd0;
        o_wr.r0  = a_v ? ra : rb;
        o_wr.r1  = rb;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE;
            r_hc   <= 8'h00;
            r_hv   <= 1'b0;
        end else if (take) begin
            r_mode <= n_mode;
            r_hc   <= n_hc;
            r_hv   <= n_hv;
        end
    end

    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == M_HALT) |=> (r_mode == M_HALT))
        else $error("halt state left without reset");

    a_halt_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == M_HALT) |-> (o_wr.cnt == 2'd0))
        else $error("result produced while halted");

    a_held_in_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hv |-> (r_mode != M_IDLE && r_mode != M_HALT))
        else $error("held character outside a token");

endmodule

// ===== rtl/core/sexl_resq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sexl_resq
// Result queue: takes up to two results per cycle, delivers one per pop.
// ----------------------------------------------------------------------------
module sexl_resq import sexl_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_sexl_wr  i_wr,
    output logic      o_room,
    output logic      empty,
    input  logic      pop,
    output t_sexl_res o_res
);

    t_sexl_res            r_mem [RESQ_DEPTH];
    logic [RESQ_AW-1:0]   r_wp;
    logic [RESQ_AW-1:0]   r_rp;
    logic [RESQ_CW-1:0]   r_cnt;
    logic                 rd_en;
    logic [RESQ_AW-1:0]   wp_nx;

    assign empty  = (r_cnt == '0);
    assign o_room = (r_cnt <= RESQ_CW'(RESQ_DEPTH - 2));
    assign o_res  = r_mem[r_rp];
    assign rd_en  = pop && !empty;
    assign wp_nx  = r_wp + RESQ_AW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + RESQ_AW'(i_wr.cnt);
            r_rp  <= r_rp + RESQ_AW'(rd_en);
            r_cnt <= r_cnt + RESQ_CW'(i_wr.cnt) - RESQ_CW'(rd_en);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.cnt != 2'd0) begin
            r_mem[r_wp] <= i_wr.r0;
        end
        if (i_wr.cnt == 2'd2) begin
            r_mem[wp_nx] <= i_wr.r1;
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= RESQ_CW'(RESQ_DEPTH))
        else $error("result queue overflow");

    a_write_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_wr.cnt != 2'd0) |-> o_room)
        else $error("result written without room");

endmodule

// ===== rtl/core/sexpr_lexer_stream_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sexpr_lexer_stream_top
// Streaming S-expression lexer, one source byte per request.
// ----------------------------------------------------------------------------
// Source bytes (or an end-of-text request) enter through a two-entry request
// queue that also classifies each byte; the lexer state machine takes one
// request per cycle while two result slots are free and writes its zero, one
// or two token-character results into a four-entry result queue. A request is
// accepted every cycle while results are drained; its results are registered
// into the result queue. The result port delivers one result per cycle while
// pop is high, so requests that yield two results (a token closed by a
// parenthesis or a bad byte, or a pending escape at end of text) take two pops,
// and the state machine waits whenever fewer than two result slots are free.
module sexpr_lexer_stream_top import sexl_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    input  t_sexl_item i_item,
    output logic       full,
    output logic       empty,
    input  logic       pop,
    output t_sexl_res  o_res
);

    logic      req_valid;
    t_sexl_req req;
    logic      req_take;
    logic      room;
    t_sexl_wr  wr;

    sexl_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .i_item      (i_item),
        .full        (full),
        .o_req_valid (req_valid),
        .o_req       (req),
        .i_req_take  (req_take)
    );

    sexl_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (req_valid),
        .i_req       (req),
        .o_req_take  (req_take),
        .i_room      (room),
        .o_wr        (wr)
    );

    sexl_resq u_resq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (wr),
        .o_room  (room),
        .empty   (empty),
        .pop     (pop),
        .o_res   (o_res)
    );

endmodule
